// File: hw/rtl/mac_route_table_with_aging_top_assert.svh
`ifndef MAC_ROUTE_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define MAC_ROUTE_TABLE_WITH_AGING_TOP_ASSERT_SVH

// same-cycle implication
`define MRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrt assertion failed");

// next-cycle implication
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrt assertion failed");

`endif

// File: hw/rtl/mrt_pkg.sv
package mrt_pkg;

   localparam int MAC_W   = 48;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 7;

   localparam logic [31:0] DEFAULT_INTERVAL = 32'd120000;
   localparam logic [33:0] EXPIRY_FACTOR    = 34'd3;
   localparam logic [CNT_W-1:0] CNT_MAX     = 7'd127;

   localparam logic [3:0] KIND_ADD    = 4'd0;
   localparam logic [3:0] KIND_REMOVE = 4'd1;
   localparam logic [3:0] KIND_SET    = 4'd2;
   localparam logic [3:0] KIND_GET    = 4'd3;
   localparam logic [3:0] KIND_EXIST  = 4'd4;
   localparam logic [3:0] KIND_ADJ    = 4'd5;
   localparam logic [3:0] KIND_LINK   = 4'd6;
   localparam logic [3:0] KIND_TICK   = 4'd7;
   localparam logic [3:0] KIND_CLEAR  = 4'd8;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [1:0]       status;
      logic [3:0]       found_link;
      logic [CNT_W-1:0] routes_removed;
   } result_type;

   typedef struct packed {
      logic             valid;
      logic [MAC_W-1:0] mac;
   } link_entry_type;

endpackage

// File: hw/rtl/mrt_ram.sv
module mrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mrt_ctrl.sv
`include "mac_route_table_with_aging_top_assert.svh"

module mrt_ctrl #(
   parameter int LINK_SLOTS    = 16,
   parameter int ROUTE_ENTRIES = 64,
   localparam int SW  = $clog2(LINK_SLOTS),
   localparam int RW  = $clog2(ROUTE_ENTRIES),
   localparam int RTW = 1 + mrt_pkg::MAC_W + SW + mrt_pkg::STAMP_W,
   localparam int LTW = 1 + mrt_pkg::MAC_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [3:0]                   in_kind,
   input  logic [3:0]                   in_link_slot,
   input  logic [mrt_pkg::MAC_W-1:0]    in_mac_a,
   input  logic [mrt_pkg::MAC_W-1:0]    in_mac_b,
   input  logic [31:0]                  interval,
   output mrt_pkg::result_type          res,
   input  logic                         res_take,
   output logic                         link_we,
   output logic [SW-1:0]                link_wa,
   output logic [LTW-1:0]               link_wd,
   output logic [SW-1:0]                link_ra,
   input  logic [LTW-1:0]               link_rd,
   output logic                         route_we,
   output logic [RW-1:0]                route_wa,
   output logic [RTW-1:0]               route_wd,
   output logic [RW-1:0]                route_ra,
   input  logic [RTW-1:0]               route_rd
);

   localparam int MAXD = (LINK_SLOTS > ROUTE_ENTRIES) ? LINK_SLOTS : ROUTE_ENTRIES;
   localparam int CW   = $clog2(MAXD + 1);
   localparam int LCW  = $clog2(LINK_SLOTS + 1);
   localparam int RCW  = $clog2(ROUTE_ENTRIES + 1);

   typedef struct packed {
      logic                          valid;
      logic [mrt_pkg::MAC_W-1:0]     dest;
      logic [SW-1:0]                 link;
      logic [mrt_pkg::STAMP_W-1:0]   stamp;
   } route_entry_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LINK, S_ROUTE, S_WRITE, S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic                       init_ff, init_in;
   logic [CW-1:0]              clr_ff, clr_in;
   logic [3:0]                 kind_ff, kind_in;
   logic [3:0]                 slot_ff, slot_in;
   logic [mrt_pkg::MAC_W-1:0]  mac_a_ff, mac_a_in, mac_b_ff, mac_b_in;
   logic [LCW-1:0]             laddr_ff, laddr_in;
   logic                       lrd_vld_ff, lrd_vld_in;
   logic [SW-1:0]              lrd_idx_ff, lrd_idx_in;
   logic [RCW-1:0]             raddr_ff, raddr_in;
   logic                       rrd_vld_ff, rrd_vld_in;
   logic [RW-1:0]              rrd_idx_ff, rrd_idx_in;
   logic                       hit_ff, hit_in, rhit_ff, rhit_in, fhit_ff, fhit_in;
   logic [RW-1:0]              tgt_ff, tgt_in, free_ff, free_in;
   logic [SW-1:0]              via_ff, via_in;
   logic [LINK_SLOTS-1:0]      drop_ff, drop_in;
   logic [31:0]                time_ff, time_in, tss_ff, tss_in;
   logic [33:0]                limit_ff, limit_in;
   logic [1:0]                 status_ff, status_in;
   logic [3:0]                 found_ff, found_in;
   logic [mrt_pkg::CNT_W-1:0]  removed_ff, removed_in;

   mrt_pkg::link_entry_type    lent;
   route_entry_type            rent, rwd;
   logic [31:0]                idle;

   assign lent     = mrt_pkg::link_entry_type'(link_rd);
   assign rent     = route_entry_type'(route_rd);
   assign idle     = time_ff - rent.stamp;
   assign in_ready = (state_ff == S_IDLE);
   assign route_wd = RTW'(rwd);

   always_comb begin
      state_in = state_ff;  init_in = init_ff;  clr_in = clr_ff;
      kind_in = kind_ff;  slot_in = slot_ff;  mac_a_in = mac_a_ff;  mac_b_in = mac_b_ff;
      laddr_in = laddr_ff;  lrd_vld_in = 1'b0;  lrd_idx_in = lrd_idx_ff;
      raddr_in = raddr_ff;  rrd_vld_in = 1'b0;  rrd_idx_in = rrd_idx_ff;
      hit_in = hit_ff;  rhit_in = rhit_ff;  fhit_in = fhit_ff;
      tgt_in = tgt_ff;  free_in = free_ff;  via_in = via_ff;  drop_in = drop_ff;
      time_in = time_ff;  tss_in = tss_ff;  limit_in = limit_ff;
      status_in = status_ff;  found_in = found_ff;  removed_in = removed_ff;
      link_we = 1'b0;  link_wa = lrd_idx_ff;  link_wd = link_rd;
      link_ra = laddr_ff[SW-1:0];
      route_we = 1'b0;  route_wa = rrd_idx_ff;  rwd = rent;
      route_ra = raddr_ff[RW-1:0];
      res = '0;
      res.status = status_ff;
      res.found_link = found_ff;
      res.routes_removed = removed_ff;

      unique case (state_ff)
         S_CLEAR: begin
            link_we  = (32'(clr_ff) < LINK_SLOTS);
            link_wa  = clr_ff[SW-1:0];
            link_wd  = '0;
            route_we = (32'(clr_ff) < ROUTE_ENTRIES);
            route_wa = clr_ff[RW-1:0];
            rwd      = '0;
            if (32'(clr_ff) == MAXD - 1) begin
               state_in = init_ff ? S_IDLE : S_DONE;
               init_in  = 1'b0;
               clr_in   = '0;
            end else begin
               clr_in = clr_ff + CW'(1);
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               kind_in = in_kind;  slot_in = in_link_slot;
               mac_a_in = in_mac_a;  mac_b_in = in_mac_b;
               status_in = mrt_pkg::ST_NOTFOUND;  found_in = '0;  removed_in = '0;
               hit_in = 1'b0;  rhit_in = 1'b0;  fhit_in = 1'b0;  drop_in = '0;
               laddr_in = '0;  raddr_in = '0;
               case (in_kind) inside
                  mrt_pkg::KIND_ADD, mrt_pkg::KIND_REMOVE, mrt_pkg::KIND_LINK: begin
                     state_in = (32'(in_link_slot) < LINK_SLOTS) ? S_LINK : S_DONE;
                  end
                  mrt_pkg::KIND_SET, mrt_pkg::KIND_ADJ: state_in = S_LINK;
                  mrt_pkg::KIND_GET, mrt_pkg::KIND_EXIST: state_in = S_ROUTE;
                  mrt_pkg::KIND_TICK: begin
                     status_in = mrt_pkg::ST_OK;
                     time_in   = time_ff + 32'd1;
                     tss_in    = tss_ff + 32'd1;
                     state_in  = S_DONE;
                     if (tss_in >= interval) begin
                        tss_in   = '0;
                        limit_in = 34'(interval) * mrt_pkg::EXPIRY_FACTOR;
                        state_in = S_ROUTE;
                     end
                  end
                  mrt_pkg::KIND_CLEAR: begin
                     status_in = mrt_pkg::ST_OK;
                     clr_in    = '0;
                     state_in  = S_CLEAR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_LINK: begin
            if (32'(laddr_ff) < LINK_SLOTS) begin
               laddr_in   = laddr_ff + LCW'(1);
               lrd_vld_in = 1'b1;
               lrd_idx_in = laddr_ff[SW-1:0];
            end
            if (lrd_vld_ff) begin
               case (kind_in)
                  mrt_pkg::KIND_ADD: begin
                     if (lrd_idx_ff == SW'(slot_ff)) begin
                        if (lent.valid && lent.mac != mac_a_ff) drop_in[lrd_idx_ff] = 1'b1;
                        link_we = 1'b1;
                        link_wd = {1'b1, mac_a_ff};
                     end else if (lent.valid && lent.mac == mac_a_ff) begin
                        drop_in[lrd_idx_ff] = 1'b1;
                        link_we = 1'b1;
                        link_wd = {1'b0, lent.mac};
                     end
                  end
                  mrt_pkg::KIND_REMOVE: begin
                     if (lrd_idx_ff == SW'(slot_ff) && lent.valid) begin
                        drop_in[lrd_idx_ff] = 1'b1;
                        link_we   = 1'b1;
                        link_wd   = {1'b0, lent.mac};
                        status_in = mrt_pkg::ST_OK;
                        found_in  = slot_ff;
                     end
                  end
                  mrt_pkg::KIND_LINK: begin
                     if (lrd_idx_ff == SW'(slot_ff) && lent.valid) begin
                        status_in = mrt_pkg::ST_OK;
                        found_in  = slot_ff;
                     end
                  end
                  mrt_pkg::KIND_ADJ: begin
                     if (!hit_ff && lent.valid && lent.mac == mac_a_ff) begin
                        hit_in    = 1'b1;
                        status_in = mrt_pkg::ST_OK;
                        found_in  = 4'(lrd_idx_ff);
                     end
                  end
                  mrt_pkg::KIND_SET: begin
                     if (!hit_ff && lent.valid && lent.mac == mac_b_ff) begin
                        hit_in = 1'b1;
                        via_in = lrd_idx_ff;
                     end
                  end
                  default: ;
               endcase
               if (32'(lrd_idx_ff) == LINK_SLOTS - 1) begin
                  case (kind_ff) inside
                     mrt_pkg::KIND_ADD: begin
                        status_in = mrt_pkg::ST_OK;
                        found_in  = slot_ff;
                        state_in  = S_ROUTE;
                     end
                     mrt_pkg::KIND_REMOVE: state_in = S_ROUTE;
                     mrt_pkg::KIND_SET: begin
                        if (mac_a_ff == mac_b_ff || !hit_in) begin
                           status_in = mrt_pkg::ST_INVALID;
                           state_in  = S_DONE;
                        end else begin
                           state_in = S_ROUTE;
                        end
                     end
                     default: state_in = S_DONE;
                  endcase
               end
            end
         end
         S_ROUTE: begin
            if (32'(raddr_ff) < ROUTE_ENTRIES) begin
               raddr_in   = raddr_ff + RCW'(1);
               rrd_vld_in = 1'b1;
               rrd_idx_in = raddr_ff[RW-1:0];
            end
            if (rrd_vld_ff) begin
               case (kind_ff) inside
                  mrt_pkg::KIND_ADD, mrt_pkg::KIND_REMOVE: begin
                     if (rent.valid && drop_ff[rent.link]) begin
                        route_we  = 1'b1;
                        rwd.valid = 1'b0;
                        if (removed_ff != mrt_pkg::CNT_MAX) removed_in = removed_ff + 7'd1;
                     end
                  end
                  mrt_pkg::KIND_GET, mrt_pkg::KIND_EXIST: begin
                     if (!rhit_ff && rent.valid && rent.dest == mac_a_ff) begin
                        rhit_in   = 1'b1;
                        status_in = mrt_pkg::ST_OK;
                        found_in  = 4'(rent.link);
                        if (kind_ff == mrt_pkg::KIND_GET) begin
                           route_we  = 1'b1;
                           rwd.stamp = time_ff;
                        end
                     end
                  end
                  mrt_pkg::KIND_SET: begin
                     if (!rhit_ff && rent.valid && rent.dest == mac_a_ff) begin
                        rhit_in = 1'b1;
                        tgt_in  = rrd_idx_ff;
                     end
                     if (!fhit_ff && !rent.valid) begin
                        fhit_in = 1'b1;
                        free_in = rrd_idx_ff;
                     end
                  end
                  mrt_pkg::KIND_TICK: begin
                     if (rent.valid && 34'(idle) > limit_ff) begin
                        route_we  = 1'b1;
                        rwd.valid = 1'b0;
                        if (removed_ff != mrt_pkg::CNT_MAX) removed_in = removed_ff + 7'd1;
                     end
                  end
                  default: ;
               endcase
               if (32'(rrd_idx_ff) == ROUTE_ENTRIES - 1) begin
                  state_in = S_DONE;
                  if (kind_ff == mrt_pkg::KIND_SET) begin
                     if (rhit_in || fhit_in) begin
                        state_in = S_WRITE;
                     end else begin
                        status_in = mrt_pkg::ST_FULL;
                     end
                  end
               end
            end
         end
         S_WRITE: begin
            route_we  = 1'b1;
            route_wa  = rhit_ff ? tgt_ff : free_ff;
            rwd       = {1'b1, mac_a_ff, via_ff, time_ff};
            status_in = mrt_pkg::ST_OK;
            found_in  = 4'(via_ff);
            state_in  = S_DONE;
         end
         S_DONE: begin
            res.valid = 1'b1;
            if (res_take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         init_ff    <= 1'b1;
         clr_ff     <= '0;
         lrd_vld_ff <= 1'b0;
         rrd_vld_ff <= 1'b0;
         time_ff    <= '0;
         tss_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         init_ff    <= init_in;
         clr_ff     <= clr_in;
         lrd_vld_ff <= lrd_vld_in;
         rrd_vld_ff <= rrd_vld_in;
         time_ff    <= time_in;
         tss_ff     <= tss_in;
      end
      kind_ff <= kind_in;  slot_ff <= slot_in;  mac_a_ff <= mac_a_in;  mac_b_ff <= mac_b_in;
      laddr_ff <= laddr_in;  lrd_idx_ff <= lrd_idx_in;
      raddr_ff <= raddr_in;  rrd_idx_ff <= rrd_idx_in;
      hit_ff <= hit_in;  rhit_ff <= rhit_in;  fhit_ff <= fhit_in;
      tgt_ff <= tgt_in;  free_ff <= free_in;  via_ff <= via_in;  drop_ff <= drop_in;
      limit_ff <= limit_in;
      status_ff <= status_in;  found_ff <= found_in;  removed_ff <= removed_in;
   end

   `MRT_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == S_IDLE, !link_we && !route_we)
   `MRT_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, in_valid && in_ready, state_ff != S_IDLE)
   `MRT_ASSERT_NEXT(a_accept_clears_count, clock, reset, in_valid && in_ready, removed_ff == '0)

endmodule

// File: hw/rtl/mac_route_table_with_aging_top.sv
// MAC route table with aging.
// Input channel req_*: one command item per accepted valid with stall low.
// Result channel rsp_*: exactly one result item per command, in order.
// Config channel csr_*: csr_data sets the scavenge interval; csr_ready is
// always high; write only while no command is in flight.
// Each walk reads one entry a cycle through the single read port of its
// memory, and the read data is registered. Set route walks the link table,
// then the route table, then writes the route; add and remove walk the link
// table, then the route table; get, probe and a scavenging tick walk the
// route table; adjacent lookup and link test walk the link table; clear
// runs the clearing pass; a tick without scavenge, an unknown kind, and add,
// remove or link test with an out-of-range slot go straight to the result.
// One command is in work at a time; the next can be taken in the cycle after
// the result moves to the output register.
// Reset: a clearing pass writes both tables empty; req_stall stays high until
// it ends.
// A result waits in the output register while rsp_stall is high; the next
// command is taken meanwhile, and its result waits in the engine.
`include "mac_route_table_with_aging_top_assert.svh"

module mac_route_table_with_aging_top #(
   parameter int LINK_SLOTS    = 16,
   parameter int ROUTE_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_kind,
   input  logic [3:0]                        req_link_slot,
   input  logic [mrt_pkg::MAC_W-1:0]         req_mac_a,
   input  logic [mrt_pkg::MAC_W-1:0]         req_mac_b,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [3:0]                        rsp_found_link,
   output logic [mrt_pkg::CNT_W-1:0]         rsp_routes_removed,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [31:0]                       csr_data
);

   localparam int SW  = $clog2(LINK_SLOTS);
   localparam int RW  = $clog2(ROUTE_ENTRIES);
   localparam int LTW = 1 + mrt_pkg::MAC_W;
   localparam int RTW = 1 + mrt_pkg::MAC_W + SW + mrt_pkg::STAMP_W;

   logic                       ready;
   mrt_pkg::result_type        res;
   logic                       take;
   logic [31:0]                interval_ff;
   logic                       rsp_valid_ff;
   logic [1:0]                 status_ff;
   logic [3:0]                 found_ff;
   logic [mrt_pkg::CNT_W-1:0]  removed_ff;

   logic            link_we, route_we;
   logic [SW-1:0]   link_wa, link_ra;
   logic [LTW-1:0]  link_wd, link_rd;
   logic [RW-1:0]   route_wa, route_ra;
   logic [RTW-1:0]  route_wd, route_rd;

   assign req_stall = !ready;
   assign csr_ready = 1'b1;
   assign take      = !rsp_valid_ff || !rsp_stall;

   mrt_ram #(.WIDTH(LTW), .DEPTH(LINK_SLOTS)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(link_ra), .rd_data(link_rd)
   );

   mrt_ram #(.WIDTH(RTW), .DEPTH(ROUTE_ENTRIES)) u_route_ram (
      .clock(clock), .wr_en(route_we), .wr_addr(route_wa), .wr_data(route_wd),
      .rd_addr(route_ra), .rd_data(route_rd)
   );

   mrt_ctrl #(.LINK_SLOTS(LINK_SLOTS), .ROUTE_ENTRIES(ROUTE_ENTRIES)) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(ready),
      .in_kind(req_kind), .in_link_slot(req_link_slot),
      .in_mac_a(req_mac_a), .in_mac_b(req_mac_b),
      .interval(interval_ff),
      .res(res), .res_take(take),
      .link_we(link_we), .link_wa(link_wa), .link_wd(link_wd),
      .link_ra(link_ra), .link_rd(link_rd),
      .route_we(route_we), .route_wa(route_wa), .route_wd(route_wd),
      .route_ra(route_ra), .route_rd(route_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= mrt_pkg::DEFAULT_INTERVAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) interval_ff <= csr_data;
         if (res.valid && take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res.valid && take) begin
         status_ff  <= res.status;
         found_ff   <= res.found_link;
         removed_ff <= res.routes_removed;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_link     = found_ff;
   assign rsp_routes_removed = removed_ff;

   `MRT_ASSERT_NEXT(a_csr_write, clock, reset, csr_valid, interval_ff == $past(csr_data))
   `MRT_ASSERT_NEXT(a_result_loaded, clock, reset, res.valid && take, rsp_valid)
   `MRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule
